[hw/rtl/ffsa_pkg.sv]
// package for the first-fit segment allocator
// widths and status codes; no dependencies
package ffsa_pkg;
    localparam int ADDR_BITS_DEF    = 20;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int LEN_W            = 21;
    localparam int OFF_W            = 20;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;
endpackage

[hw/rtl/ffsa_ram.sv]
// generic single-port-write, single-read ram with registered read
// no dependencies
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/first_fit_segment_allocator.sv]
// first-fit segment allocator: top level with sequencer and segment table ram
// depends on ffsa_pkg and ffsa_ram
// the table is walked one entry a cycle; a result word follows its request word through
// the scan, any move of entries and the writes (a split with a full move is the slowest)
// one request in flight: a new request word is taken only while the sequencer is idle;
// a waiting result only holds the sequencer in its last state, the next word is taken
// reset writes entry 0 as one free segment over the whole heap in S_INIT, inputs
// are held off until then; a heap_bytes write rebuilds the table the same way
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,     // heap_bytes[20:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,      // action, request_bytes[20:0], release_offset[19:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata       // status[1:0], block_offset[19:0], block_bytes[20:0]
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = IW + 1;
    localparam int EW = OFF_W + LEN_W + 1;
    localparam logic [LEN_W:0] HEAP_MAX = (LEN_W + 1)'(64'd1 << ADDR_BITS_DEF);
    localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);
    localparam logic [OFF_W-1:0] OMASK = OFF_W'((64'd1 << ADDR_BITS_DEF) - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_SCAN, S_SHR, S_SHIFT, S_WLO, S_WHI, S_FREE, S_DEL, S_OUT
    } state_t;

    state_t           state_reg;
    logic [CW-1:0]    count_reg;
    logic [IW-1:0]    idx_reg, fit_reg;
    logic             act_reg;
    logic [LEN_W-1:0] req_reg;
    logic [OFF_W-1:0] off_reg;
    logic [EW-1:0]    cur_reg;
    logic [EW-1:0]    prev_reg;
    logic             hasprev_reg;
    logic             mergehi_reg;
    logic [1:0]       gap_reg;
    logic [1:0]       st_reg;
    logic [OFF_W-1:0] ooff_reg;
    logic [LEN_W-1:0] olen_reg;
    logic [1:0]       ostat_reg;
    logic [OFF_W-1:0] oofs_reg;
    logic [LEN_W-1:0] obytes_reg;
    logic             ovalid_reg;

    logic             we;
    logic [IW-1:0]    waddr, raddr;
    logic [EW-1:0]    wdata, rdata;

    ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_tab (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // entry fields: {offset, length, free}
    logic [OFF_W-1:0] r_off;
    logic [LEN_W-1:0] r_len;
    logic             r_free;
    assign r_off  = rdata[EW-1 -: OFF_W];
    assign r_len  = rdata[LEN_W:1];
    assign r_free = rdata[0];

    logic [LEN_W-1:0] cfg_clamp;
    always_comb
    begin
        cfg_clamp = cfg_data[LEN_W-1:0];
        if (cfg_clamp == '0)
            cfg_clamp = LEN_W'(1);
        if ({1'b0, cfg_clamp} > HEAP_MAX)
            cfg_clamp = HEAP_MAX[LEN_W-1:0];
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {5'd0, obytes_reg, oofs_reg, ostat_reg};

    logic [OFF_W-1:0] cur_off;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] rem_len;
    logic [OFF_W-1:0] split_off;
    assign cur_off   = cur_reg[EW-1 -: OFF_W];
    assign cur_len   = cur_reg[LEN_W:1];
    assign rem_len   = cur_len - req_reg;
    assign split_off = (cur_off + OFF_W'(req_reg)) & OMASK;

    // free: rdata holds the entry above, prev_reg the entry below
    logic             hi_m, lo_m;
    logic [LEN_W-1:0] merged_len;
    logic [IW-1:0]    merge_at;
    logic [OFF_W-1:0] merge_off;
    logic [1:0]       gap;
    logic [CW-1:0]    src_c;
    assign hi_m       = mergehi_reg && r_free;
    assign lo_m       = hasprev_reg && prev_reg[0];
    assign merged_len = cur_len + (hi_m ? r_len : '0) + (lo_m ? prev_reg[LEN_W:1] : '0);
    assign merge_at   = lo_m ? fit_reg - IW'(1) : fit_reg;
    assign merge_off  = lo_m ? prev_reg[EW-1 -: OFF_W] : cur_off;
    assign gap        = {1'b0, lo_m} + {1'b0, hi_m};
    assign src_c      = {1'b0, fit_reg} + CW'(1) + CW'(hi_m);

    always_comb
    begin
        we = 1'b0; waddr = idx_reg; wdata = cur_reg; raddr = idx_reg;
        unique case (state_reg)
            S_INIT:  begin
                we = 1'b1; waddr = '0; wdata = {{OFF_W{1'b0}}, HEAP_MAX[LEN_W-1:0], 1'b1};
            end
            S_IDLE:  begin
                raddr = '0;
                if (cfg_valid)
                begin
                    we = 1'b1; waddr = '0; wdata = {{OFF_W{1'b0}}, cfg_clamp, 1'b1};
                end
            end
            S_SCAN:  raddr = idx_reg + IW'(1);
            S_SHIFT: begin
                // rdata is entry idx_reg, moved up by one
                we = 1'b1; waddr = idx_reg + IW'(1); wdata = rdata;
                raddr = idx_reg - IW'(1);
            end
            S_WLO:   begin
                we = 1'b1; waddr = fit_reg; wdata = {cur_off, req_reg, 1'b0};
            end
            S_WHI:   begin
                we = 1'b1; waddr = fit_reg + IW'(1); wdata = {split_off, rem_len, 1'b1};
            end
            S_FREE:  begin
                we = 1'b1; waddr = merge_at; wdata = {merge_off, merged_len, 1'b1};
                raddr = IW'(src_c);
            end
            S_DEL:   begin
                // rdata is entry idx_reg, moved down by the merged count
                we = 1'b1; waddr = idx_reg - IW'(gap_reg); wdata = rdata;
                raddr = idx_reg + IW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            count_reg   <= CW'(1);
            ovalid_reg  <= 1'b0;
            idx_reg     <= '0;
            fit_reg     <= '0;
            hasprev_reg <= 1'b0;
            mergehi_reg <= 1'b0;
            gap_reg     <= '0;
            act_reg     <= 1'b0;
            st_reg      <= ST_OK;
            prev_reg    <= '0;
            cur_reg     <= '0;
            ooff_reg    <= '0;
            olen_reg    <= '0;
            req_reg     <= '0;
            off_reg     <= '0;
            ostat_reg   <= ST_OK;
            oofs_reg    <= '0;
            obytes_reg  <= '0;
        end
        else
        begin
            if (state_reg == S_OUT && (!ovalid_reg || m_tready))
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_INIT: state_reg <= S_IDLE;
                S_IDLE: begin
                    if (cfg_valid)
                    begin
                        count_reg <= CW'(1);
                    end
                    else if (s_tvalid)
                    begin
                        act_reg     <= s_tdata[0];
                        req_reg     <= s_tdata[21:1];
                        off_reg     <= s_tdata[41:22];
                        idx_reg     <= '0;
                        hasprev_reg <= 1'b0;
                        state_reg   <= S_RD;
                    end
                end
                S_RD: state_reg <= S_SCAN;
                S_SCAN: begin
                    // rdata holds entry idx_reg
                    if (!act_reg)
                    begin
                        if (req_reg == '0)
                        begin
                            st_reg <= ST_NOFIT; ooff_reg <= '0; olen_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else if (r_free && r_len >= req_reg)
                        begin
                            cur_reg <= rdata; fit_reg <= idx_reg;
                            if (r_len == req_reg)
                            begin
                                st_reg <= ST_OK; ooff_reg <= r_off; olen_reg <= req_reg;
                                state_reg <= S_WLO;
                            end
                            else if (count_reg >= CMAX)
                            begin
                                st_reg <= ST_FULL; ooff_reg <= '0; olen_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                st_reg <= ST_OK; ooff_reg <= r_off; olen_reg <= req_reg;
                                if ({1'b0, idx_reg} + CW'(1) == count_reg)
                                begin
                                    state_reg <= S_WLO;
                                end
                                else
                                begin
                                    idx_reg   <= IW'(count_reg - CW'(1));
                                    state_reg <= S_SHR;   // read top entry first
                                end
                            end
                        end
                        else if ({1'b0, idx_reg} + CW'(1) >= count_reg)
                        begin
                            st_reg <= ST_NOFIT; ooff_reg <= '0; olen_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        if (r_off == off_reg)
                        begin
                            if (r_free)
                            begin
                                st_reg <= ST_BADFREE; ooff_reg <= off_reg; olen_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                cur_reg <= rdata; fit_reg <= idx_reg;
                                mergehi_reg <= ({1'b0, idx_reg} + CW'(1) < count_reg);
                                state_reg <= S_FREE;
                            end
                        end
                        else if ({1'b0, idx_reg} + CW'(1) >= count_reg)
                        begin
                            st_reg <= ST_BADFREE; ooff_reg <= off_reg; olen_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            prev_reg <= rdata; hasprev_reg <= 1'b1;
                            idx_reg <= idx_reg + IW'(1);
                        end
                    end
                end
                S_SHR: state_reg <= S_SHIFT;
                S_SHIFT: begin
                    if (idx_reg == fit_reg + IW'(1))
                        state_reg <= S_WLO;
                    else
                        idx_reg <= idx_reg - IW'(1);
                end
                S_WLO: begin
                    if (rem_len == '0)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_WHI;
                end
                S_WHI: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_OUT;
                end
                S_FREE: begin
                    st_reg   <= ST_OK;
                    ooff_reg <= off_reg;
                    olen_reg <= merged_len;
                    gap_reg  <= gap;
                    if (gap == 2'd0 || src_c >= count_reg)
                    begin
                        count_reg <= count_reg - CW'(gap);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= IW'(src_c);
                        state_reg <= S_DEL;
                    end
                end
                S_DEL: begin
                    if ({1'b0, idx_reg} + CW'(1) >= count_reg)
                    begin
                        count_reg <= count_reg - CW'(gap_reg);
                        state_reg <= S_OUT;
                    end
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                S_OUT: begin
                    if (!ovalid_reg || m_tready)
                    begin
                        ostat_reg  <= st_reg;
                        oofs_reg   <= ooff_reg;
                        obytes_reg <= olen_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    property p_one_result;
        @(posedge clk) disable iff (!rst_n)
            (ovalid_reg && !m_tready) |=> (ovalid_reg && $stable(m_tdata));
    endproperty
    a_hold: assert property (p_one_result) else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready) else $error("accept while busy");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(1)) && (count_reg <= CMAX)) else $error("count out of range");
endmodule
